// File: rtl/core/pps_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pps_pkg: shared types and constants of the priority scheduler
// Table sizes, field widths, command word and a saturating time helper.
// ---------------------------------------------------------------------------
package pps_pkg;

  localparam int MAX_JOBS   = 16;
  localparam int TIME_BITS  = 16;
  localparam int WORK_W     = 16;                       // burst and priority width
  localparam int FIELD_W    = 16;                       // width of time fields on ports
  localparam int SLOT_W     = 4;                        // slot field on ports
  localparam int CFG_W      = 5;                        // job_count register
  localparam int DONE_W     = 5;
  localparam int SLOT_BITS  = $clog2(MAX_JOBS);
  localparam int JOBS_W     = $clog2(MAX_JOBS + 1);
  localparam int CALC_W     = (TIME_BITS > WORK_W) ? TIME_BITS : WORK_W;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
  localparam logic [DONE_W-1:0]    DONE_MAX = '1;

  // action codes on the input side-band
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_TICK,
    KIND_START,
    KIND_NOP
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic                  slot_ok;
    logic [SLOT_BITS-1:0]  slot;
    logic [TIME_BITS-1:0]  arrival;
    logic [WORK_W-1:0]     burst;
    logic [WORK_W-1:0]     prio;
  } cmd_t;

  typedef struct packed {
    logic              full;
    logic              empty;
  } fifo_stat_t;

  typedef struct packed {
    logic              ran;
    logic [SLOT_W-1:0] served_slot;
    logic              finished;
    logic [FIELD_W-1:0] completion_time;
    logic [FIELD_W-1:0] turnaround_time;
    logic [FIELD_W-1:0] waiting_time;
    logic              all_done;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_CALC,
    ST_EMIT
  } eng_state_t;

  function automatic logic [TIME_BITS-1:0] sat_inc(input logic [TIME_BITS-1:0] t);
    sat_inc = (t == TIME_MAX) ? TIME_MAX : t + 1'b1;
  endfunction

endpackage

// File: rtl/core/pps_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pps_front: input decode
// Classify the incoming word by action and push a command into the queue.
// ---------------------------------------------------------------------------
module pps_front (
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [1:0]            in_tuser,
  input  logic [55:0]           in_tdata,
  input  pps_pkg::fifo_stat_t   q_stat,
  output logic                  push,
  output pps_pkg::cmd_t         cmd
);
  import pps_pkg::*;

  logic [SLOT_W-1:0] slot_in;

  assign in_tready = !q_stat.full;
  assign push      = in_tvalid && !q_stat.full;
  assign slot_in   = in_tdata[3:0];

  always_comb begin
    unique case (in_tuser)
      ACT_LOAD:  cmd.kind = KIND_LOAD;
      ACT_TICK:  cmd.kind = KIND_TICK;
      ACT_START: cmd.kind = KIND_START;
      default:   cmd.kind = KIND_NOP;
    endcase
    // loads beyond the table are dropped by the engine
    cmd.slot_ok = int'(slot_in) < MAX_JOBS;
    cmd.slot    = SLOT_BITS'(slot_in);
    cmd.arrival = TIME_BITS'(in_tdata[19:4]);
    cmd.burst   = in_tdata[35:20];
    cmd.prio    = in_tdata[51:36];
  end

endmodule

// File: rtl/core/pps_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pps_fifo: command queue
// Short FIFO between decode and the scheduling engine.
// ---------------------------------------------------------------------------
module pps_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  pps_pkg::cmd_t        push_data,
  input  logic                 pop,
  output pps_pkg::cmd_t        pop_data,
  output pps_pkg::fifo_stat_t  stat
);
  import pps_pkg::*;

  cmd_t               entry_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0] count_r, count_nxt;

  function automatic logic [FIFO_AW-1:0] ptr_inc(input logic [FIFO_AW-1:0] p);
    ptr_inc = (int'(p) == FIFO_DEPTH - 1) ? '0 : p + 1'b1;
  endfunction

  assign stat.full  = (int'(count_r) == FIFO_DEPTH);
  assign stat.empty = (count_r == '0);
  assign pop_data   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: rtl/core/pps_engine.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pps_engine: scheduling engine
// Hold the job tables, scan them one slot a cycle per tick, update the
// winner and register one result per command.
// ---------------------------------------------------------------------------
module pps_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [pps_pkg::CFG_W-1:0]   job_count,
  input  pps_pkg::fifo_stat_t         q_stat,
  input  pps_pkg::cmd_t               q_data,
  output logic                        pop,
  output logic                        res_valid,
  input  logic                        res_ready,
  output pps_pkg::res_t               res
);
  import pps_pkg::*;

  // job tables
  logic [TIME_BITS-1:0] arr_mem  [MAX_JOBS];
  logic [WORK_W-1:0]    rem_mem  [MAX_JOBS];
  logic [WORK_W-1:0]    orig_mem [MAX_JOBS];
  logic [WORK_W-1:0]    pri_mem  [MAX_JOBS];

  logic [TIME_BITS-1:0] rd_arr_r;
  logic [WORK_W-1:0]    rd_rem_r, rd_orig_r, rd_pri_r;
  logic [SLOT_BITS-1:0] rd_addr;

  logic                 load_we;
  logic                 rem_we;
  logic [SLOT_BITS-1:0] wr_addr;
  logic [WORK_W-1:0]    rem_wdata;

  eng_state_t           state_r, state_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic [TIME_BITS-1:0] tick_r, tick_nxt;
  logic [DONE_W-1:0]    done_r, done_nxt;
  logic [SLOT_BITS-1:0] idx_r, idx_nxt;
  logic                 cmp_vld_r, cmp_vld_nxt;
  logic [SLOT_BITS-1:0] cmp_idx_r, cmp_idx_nxt;
  logic                 found_r, found_nxt;
  logic [SLOT_BITS-1:0] best_idx_r, best_idx_nxt;
  logic [TIME_BITS-1:0] best_arr_r, best_arr_nxt;
  logic [WORK_W-1:0]    best_rem_r, best_rem_nxt;
  logic [WORK_W-1:0]    best_orig_r, best_orig_nxt;
  logic [WORK_W-1:0]    best_pri_r, best_pri_nxt;
  logic [TIME_BITS-1:0] ct_r, ct_nxt;
  logic [CALC_W-1:0]    tt_r, tt_nxt;
  logic                 res_vld_r, res_vld_nxt;
  res_t                 res_r, res_nxt;

  logic [JOBS_W-1:0]    n_jobs;
  logic                 eligible;
  logic                 fin;
  logic [CALC_W-1:0]    ct_ext, arr_ext, orig_ext, wt;

  assign n_jobs = (int'(job_count) > MAX_JOBS) ? JOBS_W'(MAX_JOBS) : JOBS_W'(job_count);

  assign eligible = cmp_vld_r && (rd_arr_r <= tick_r) && (rd_rem_r != '0) &&
                    (!found_r || (rd_pri_r < best_pri_r));

  assign ct_ext   = CALC_W'(ct_r);
  assign arr_ext  = CALC_W'(best_arr_r);
  assign orig_ext = CALC_W'(best_orig_r);
  assign fin      = found_r && (best_rem_r == WORK_W'(1));
  assign wt       = (tt_r >= orig_ext) ? tt_r - orig_ext : '0;

  assign res_valid = res_vld_r;
  assign res       = res_r;
  assign rd_addr   = idx_r;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    tick_nxt      = tick_r;
    done_nxt      = done_r;
    idx_nxt       = idx_r;
    cmp_vld_nxt   = 1'b0;
    cmp_idx_nxt   = cmp_idx_r;
    found_nxt     = found_r;
    best_idx_nxt  = best_idx_r;
    best_arr_nxt  = best_arr_r;
    best_rem_nxt  = best_rem_r;
    best_orig_nxt = best_orig_r;
    best_pri_nxt  = best_pri_r;
    ct_nxt        = ct_r;
    tt_nxt        = tt_r;
    res_vld_nxt   = res_vld_r && !res_ready;
    res_nxt       = res_r;
    pop           = 1'b0;
    load_we       = 1'b0;
    rem_we        = 1'b0;
    wr_addr       = cmd_r.slot;
    rem_wdata     = best_rem_r - 1'b1;

    // fold the slot read last cycle into the running best
    if (eligible) begin
      found_nxt     = 1'b1;
      best_idx_nxt  = cmp_idx_r;
      best_arr_nxt  = rd_arr_r;
      best_rem_nxt  = rd_rem_r;
      best_orig_nxt = rd_orig_r;
      best_pri_nxt  = rd_pri_r;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          pop     = 1'b1;
          cmd_nxt = q_data;
          ct_nxt  = sat_inc(tick_r);
          wr_addr = q_data.slot;
          unique case (q_data.kind)
            KIND_LOAD: begin
              load_we   = q_data.slot_ok;
              state_nxt = ST_EMIT;
            end
            KIND_TICK: begin
              idx_nxt   = '0;
              found_nxt = 1'b0;
              state_nxt = (n_jobs == '0) ? ST_CALC : ST_SCAN;
            end
            default: begin
              state_nxt = ST_EMIT;
            end
          endcase
        end
      end
      ST_SCAN: begin
        cmp_vld_nxt = 1'b1;
        cmp_idx_nxt = idx_r;
        idx_nxt     = idx_r + 1'b1;
        if (JOBS_W'(idx_r) == n_jobs - 1'b1) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_CALC;
      end
      ST_CALC: begin
        tt_nxt    = (ct_ext >= arr_ext) ? ct_ext - arr_ext : '0;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!res_vld_r || res_ready) begin
          res_vld_nxt = 1'b1;
          res_nxt     = '0;
          unique case (cmd_r.kind)
            KIND_TICK: begin
              if (found_r) begin
                rem_we              = 1'b1;
                wr_addr             = best_idx_r;
                res_nxt.ran         = 1'b1;
                res_nxt.served_slot = SLOT_W'(best_idx_r);
                if (fin) begin
                  res_nxt.finished        = 1'b1;
                  res_nxt.completion_time = FIELD_W'(ct_r);
                  res_nxt.turnaround_time = FIELD_W'(tt_r);
                  res_nxt.waiting_time    = FIELD_W'(wt);
                  if (done_r != DONE_MAX) begin
                    done_nxt = done_r + 1'b1;
                  end
                end
              end
              tick_nxt = ct_r;
            end
            KIND_START: begin
              tick_nxt = '0;
              done_nxt = '0;
            end
            default: begin
            end
          endcase
          res_nxt.all_done = int'(done_nxt) >= int'(n_jobs);
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      tick_r    <= '0;
      done_r    <= '0;
      cmp_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      tick_r    <= tick_nxt;
      done_r    <= done_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    idx_r       <= idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    found_r     <= found_nxt;
    best_idx_r  <= best_idx_nxt;
    best_arr_r  <= best_arr_nxt;
    best_rem_r  <= best_rem_nxt;
    best_orig_r <= best_orig_nxt;
    best_pri_r  <= best_pri_nxt;
    ct_r        <= ct_nxt;
    tt_r        <= tt_nxt;
    res_r       <= res_nxt;
  end

  // table write port: a load fills a whole slot, a served tick rewrites remaining work
  always_ff @(posedge clk) begin
    if (load_we) begin
      arr_mem[wr_addr]  <= q_data.arrival;
      rem_mem[wr_addr]  <= q_data.burst;
      orig_mem[wr_addr] <= q_data.burst;
      pri_mem[wr_addr]  <= q_data.prio;
    end else if (rem_we) begin
      rem_mem[wr_addr]  <= rem_wdata;
    end
  end

  // table read port, one slot a cycle
  always_ff @(posedge clk) begin
    rd_arr_r  <= arr_mem[rd_addr];
    rd_rem_r  <= rem_mem[rd_addr];
    rd_orig_r <= orig_mem[rd_addr];
    rd_pri_r  <= pri_mem[rd_addr];
  end

endmodule

// File: rtl/core/preemptive_priority_scheduler.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// preemptive_priority_scheduler: tick-driven preemptive priority scheduler
// Load jobs into a table, then on each tick serve the ready job with the
// smallest priority number and report completion statistics.
// ---------------------------------------------------------------------------
//
//  Channel  Direction  Handshake              Word
//  in_      slave      in_tvalid/in_tready    tuser = action, tdata = job
//  out_     master     out_tvalid/out_tready  tdata = per-word result
//  cfg_     slave      cfg_valid/cfg_ready    cfg_data = job_count
//
// For a tick word the engine takes the word from the queue, reads one table
// slot per cycle (job_count slots, capped at 16; none with job_count 0) through
// the single table read port, drains the read, works out turnaround and then
// writes back the result. Load, start and unknown words go from the queue
// straight to the result write.
// A two-word command queue lets the input side keep taking words while the
// engine scans or while a result waits in the output register.
// Reset (rst_n low, synchronous) clears tick time, done count, job_count and
// all handshake state; the job tables hold garbage until loaded.
// A stalled out_tready holds the result and backs up the queue, then in_tready.
// ---------------------------------------------------------------------------
module preemptive_priority_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] action
  input  logic [55:0] in_tdata,   // [3:0] slot, [19:4] arrival_time,
                                  // [35:20] burst_length, [51:36] priority_level
  // result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [0] ran, [4:1] served_slot, [5] finished,
                                  // [21:6] completion_time, [37:22] turnaround_time,
                                  // [53:38] waiting_time, [54] all_done
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);
  import pps_pkg::*;

  logic [CFG_W-1:0] job_count_r;

  fifo_stat_t q_stat;
  cmd_t       push_cmd;
  cmd_t       pop_cmd;
  logic       push;
  logic       pop;
  res_t       res;

  // job_count is to be written only while idle; the block does not enforce this, cfg_ready is tied high
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_count_r <= '0;
    end else if (cfg_valid) begin
      job_count_r <= cfg_data;
    end
  end

  // decode and classify incoming words
  pps_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .push      (push),
    .cmd       (push_cmd)
  );

  // decouple decode from the engine
  pps_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_cmd),
    .pop       (pop),
    .pop_data  (pop_cmd),
    .stat      (q_stat)
  );

  // table scan, winner update and result register
  pps_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_count (job_count_r),
    .q_stat    (q_stat),
    .q_data    (pop_cmd),
    .pop       (pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  // pack the result, lowest field first, pad to whole bytes
  assign out_tdata = {1'b0, res.all_done, res.waiting_time, res.turnaround_time,
                      res.completion_time, res.finished, res.served_slot, res.ran};

endmodule

// File: test/pps_result_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pps_result_checker: result checker for the priority scheduler
// Tracks the scheduler's tables from the accepted words, predicts the
// result word of every input word and compares it field by field.
// ---------------------------------------------------------------------------
module pps_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] action
  input  logic [55:0] in_tdata,   // [3:0] slot, [19:4] arrival_time,
                                  // [35:20] burst_length, [51:36] priority_level
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,  // [0] ran, [4:1] served_slot, [5] finished,
                                  // [21:6] completion_time, [37:22] turnaround_time,
                                  // [53:38] waiting_time, [54] all_done
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  output int          pending,
  output int          errors
);
  import pps_pkg::*;

  // shadow copy of the job table and the scheduler state
  logic [TIME_BITS-1:0] arrival_at [MAX_JOBS];
  logic [WORK_W-1:0]    work_left  [MAX_JOBS];
  logic [WORK_W-1:0]    burst_len  [MAX_JOBS];
  logic [WORK_W-1:0]    urgency    [MAX_JOBS];
  logic [TIME_BITS-1:0] now_tick;
  logic [DONE_W-1:0]    jobs_done;
  logic [CFG_W-1:0]     job_limit;

  res_t outcome_q [$];
  int   result_idx;

  task automatic flag_mismatch(input string what, input longint got_v, input longint want_v);
    // keep the log short on a badly broken design
    if (errors < 40)
      $display("mismatch in result word %0d, %s: got %0d, expected %0d",
               result_idx, what, got_v, want_v);
    errors++;
  endtask

  // apply one word to the shadow state and return the result it must produce
  function automatic res_t schedule_word(input logic [1:0] action, input logic [55:0] word);
    res_t                 r;
    logic [SLOT_W-1:0]    slot;
    logic [TIME_BITS-1:0] fin_at;
    logic [TIME_BITS-1:0] span;
    int                   n;
    int                   best;
    int                   i;
    bit                   found;
    r     = '0;
    slot  = word[3:0];
    n     = (job_limit > MAX_JOBS) ? MAX_JOBS : int'(job_limit);
    found = 1'b0;
    best  = 0;
    case (action)
      ACT_LOAD: begin
        arrival_at[slot] = word[19:4];
        work_left[slot]  = word[35:20];
        burst_len[slot]  = word[35:20];
        urgency[slot]    = word[51:36];
      end
      ACT_START: begin
        now_tick  = '0;
        jobs_done = '0;
      end
      ACT_TICK: begin
        // strict less-than keeps the lowest slot on a priority tie
        for (i = 0; i < n; i++) begin
          if (arrival_at[i] <= now_tick && work_left[i] != '0 &&
              (!found || urgency[i] < urgency[best])) begin
            found = 1'b1;
            best  = i;
          end
        end
        if (found) begin
          r.ran         = 1'b1;
          r.served_slot = best[SLOT_W-1:0];
          work_left[best] = work_left[best] - 1'b1;
          if (work_left[best] == '0) begin
            r.finished = 1'b1;
            if (jobs_done != DONE_MAX) jobs_done = jobs_done + 1'b1;
            fin_at = (now_tick == TIME_MAX) ? TIME_MAX : now_tick + 1'b1;
            span   = (fin_at >= arrival_at[best]) ? fin_at - arrival_at[best] : '0;
            r.completion_time = fin_at;
            r.turnaround_time = span;
            // clamp at zero when a start cut the run short
            r.waiting_time    = (span >= burst_len[best]) ? span - burst_len[best] : '0;
          end
        end
        if (now_tick != TIME_MAX) now_tick = now_tick + 1'b1;
      end
      default: ;
    endcase
    r.all_done = (int'(jobs_done) >= n);
    return r;
  endfunction

  task automatic check_result(input logic [55:0] word);
    res_t got;
    res_t want;
    got.ran             = word[0];
    got.served_slot     = word[4:1];
    got.finished        = word[5];
    got.completion_time = word[21:6];
    got.turnaround_time = word[37:22];
    got.waiting_time    = word[53:38];
    got.all_done        = word[54];
    if (outcome_q.size() == 0) begin
      if (errors < 40) $display("unexpected result word %0d: nothing pending", result_idx);
      errors++;
    end else begin
      want = outcome_q.pop_front();
      if (got.ran != want.ran)
        flag_mismatch("ran", longint'(got.ran), longint'(want.ran));
      if (got.served_slot != want.served_slot)
        flag_mismatch("served_slot", longint'(got.served_slot), longint'(want.served_slot));
      if (got.finished != want.finished)
        flag_mismatch("finished", longint'(got.finished), longint'(want.finished));
      if (got.completion_time != want.completion_time)
        flag_mismatch("completion_time", longint'(got.completion_time),
                      longint'(want.completion_time));
      if (got.turnaround_time != want.turnaround_time)
        flag_mismatch("turnaround_time", longint'(got.turnaround_time),
                      longint'(want.turnaround_time));
      if (got.waiting_time != want.waiting_time)
        flag_mismatch("waiting_time", longint'(got.waiting_time),
                      longint'(want.waiting_time));
      if (got.all_done != want.all_done)
        flag_mismatch("all_done", longint'(got.all_done), longint'(want.all_done));
    end
    result_idx++;
  endtask

  initial begin
    errors     = 0;
    pending    = 0;
    result_idx = 0;
    now_tick   = '0;
    jobs_done  = '0;
    job_limit  = '0;
    for (int i = 0; i < MAX_JOBS; i++) begin
      arrival_at[i] = '0;
      work_left[i]  = '0;
      burst_len[i]  = '0;
      urgency[i]    = '0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      now_tick  = '0;
      jobs_done = '0;
      job_limit = '0;
      outcome_q.delete();
    end else begin
      // check results before queuing, so a result never meets its own word
      if (out_tvalid && out_tready) check_result(out_tdata);
      if (cfg_valid && cfg_ready) job_limit = cfg_data;
      if (in_tvalid && in_tready) outcome_q.push_back(schedule_word(in_tuser, in_tdata));
    end
    pending = outcome_q.size();
  end

endmodule

// File: test/preemptive_priority_scheduler_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// preemptive_priority_scheduler_test: top-level test of the priority scheduler
// Drives load, tick, start and stray words plus job_count writes with random
// idle gaps and output stalls; a separate checker predicts every result.
// ---------------------------------------------------------------------------
module preemptive_priority_scheduler_test;
  import pps_pkg::*;

  // action code the block must ignore
  localparam logic [1:0] ACT_UNKNOWN = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [1:0]  in_tuser;   // [1:0] action
  logic [55:0] in_tdata;   // [3:0] slot, [19:4] arrival_time,
                           // [35:20] burst_length, [51:36] priority_level
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;  // [0] ran, [4:1] served_slot, [5] finished,
                           // [21:6] completion_time, [37:22] turnaround_time,
                           // [53:38] waiting_time, [54] all_done
  logic        cfg_valid;
  logic        cfg_ready;
  logic [4:0]  cfg_data;

  int pending;
  int errors;

  // steady: no gaps on either side
  bit steady;
  int words_sent;
  // rough amount of work loaded in the current phase, used to size the tick run
  int work_sum;
  int late_arrival;

  preemptive_priority_scheduler i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  pps_result_checker i_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .errors     (errors)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // gap length: mostly none or short, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // present one word at the falling edge and hold it until it is taken;
  // returns right after the following falling edge
  task automatic send_word(input logic [1:0] action, input logic [3:0] slot,
                           input logic [15:0] arr, input logic [15:0] burst,
                           input logic [15:0] prio);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = action;
    in_tdata  = {4'h0, prio, burst, arr, slot};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (action != ACT_UNKNOWN) words_sent++;
  endtask

  // hold the sender until every pending result is out
  task automatic drain();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // write job_count only with the block idle
  task automatic write_job_count(input logic [4:0] value);
    drain();
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // load a job: mostly small times and bursts so jobs finish, with a few
  // full-range words to toggle every bit
  task automatic load_random_job(input int slot);
    logic [15:0] arr;
    logic [15:0] burst;
    logic [15:0] prio;
    if ($urandom_range(0, 9) == 0) begin
      arr   = 16'($urandom);
      burst = 16'($urandom);
      prio  = 16'($urandom);
    end else begin
      arr   = 16'($urandom_range(0, 12));
      burst = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
      // a narrow priority range makes ties and preemption common
      prio  = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
    end
    if (burst <= 16) work_sum += int'(burst);
    if (arr <= 16 && arr > late_arrival) late_arrival = int'(arr);
    send_word(ACT_LOAD, slot[3:0], arr, burst, prio);
  endtask

  // output side: bursts of ready with random stalls in between
  initial begin
    int stall;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (steady) begin
        out_tready = 1'b1;
      end else begin
        out_tready = 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        stall = idle_len();
        if (stall > 0) begin
          out_tready = 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
    end
  end

  // stimulus and verdict
  initial begin
    int phase;
    int limit;
    int n_jobs;
    int ticks;
    int r;
    logic [15:0] arr;
    logic [15:0] burst;
    logic [15:0] prio;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = ACT_LOAD;
    in_tdata   = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    steady     = 1'b0;
    words_sent = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty table, stray action, fill every slot with edge values
    send_word(ACT_TICK, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_word(ACT_UNKNOWN, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (int s = 0; s < MAX_JOBS; s++) begin
      arr   = (s == 15) ? 16'hFFFF : 16'(s % 4);
      burst = (s == 15) ? 16'hFFFF : (s == 1) ? 16'd0 : 16'(1 + s % 3);
      // slot 0 most urgent, slots 2 and 3 tie, slot 15 least urgent
      prio  = (s == 0) ? 16'd0 : (s == 15) ? 16'hFFFF : (s == 2 || s == 3) ? 16'd5 :
              16'(7 + s);
      send_word(ACT_LOAD, s[3:0], arr, burst, prio);
    end
    write_job_count(5'd16);
    send_word(ACT_START, 4'h0, 16'h0, 16'h0, 16'h0);
    repeat (5) send_word(ACT_TICK, 4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));

    // one job that arrives at the last tick: it never gets ready, so every
    // tick runs with nothing to serve
    write_job_count(5'd1);
    send_word(ACT_LOAD, 4'h0, 16'hFFFF, 16'd2, 16'($urandom));
    send_word(ACT_START, 4'h0, 16'h0, 16'h0, 16'h0);
    steady = 1'b1;
    repeat (20) send_word(ACT_TICK, 4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    steady = 1'b0;

    // random phases: set job_count, reload the jobs in use, start, then tick
    words_sent = 0;
    phase      = 0;
    while (words_sent < 1300) begin
      case (phase)
        0: limit = 16;
        1: limit = 31;
        2: limit = 0;
        3: limit = 17;
        default: begin
          r = $urandom_range(0, 9);
          if (r < 6)      limit = $urandom_range(2, 8);
          else if (r < 8) limit = $urandom_range(1, 16);
          else            limit = $urandom_range(0, 31);
        end
      endcase
      write_job_count(limit[4:0]);
      steady       = ($urandom_range(0, 5) == 0);
      n_jobs       = (limit > MAX_JOBS) ? MAX_JOBS : limit;
      work_sum     = 0;
      late_arrival = 0;
      for (int s = 0; s < n_jobs; s++) load_random_job(s);
      send_word(ACT_START, 4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      ticks = work_sum + late_arrival + $urandom_range(0, 4);
      if (ticks > 80) ticks = 80;
      repeat (ticks) begin
        r = $urandom_range(0, 99);
        // mix in reloads, restarts and stray words between ticks
        if (r < 7 && n_jobs > 0) load_random_job($urandom_range(0, n_jobs - 1));
        else if (r < 9)
          send_word(ACT_START, 4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        else if (r < 11)
          send_word(ACT_UNKNOWN, 4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        send_word(ACT_TICK, 4'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end
      phase++;
    end
    steady = 1'b0;

    drain();
    // catch stray results after the last expected one
    repeat (40) @(negedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #20000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: preemptive_priority_scheduler.f
rtl/core/pps_pkg.sv
rtl/core/pps_front.sv
rtl/core/pps_fifo.sv
rtl/core/pps_engine.sv
rtl/core/preemptive_priority_scheduler.sv
test/pps_result_checker.sv
test/preemptive_priority_scheduler_test.sv
